// File: src/feac_pkg.sv
// Shared types and constants for the free extent allocator.
// Used by the controller, the datapath and the top level.
package feac_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] block_size;
    logic [31:0] block_address;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [31:0] granted_size;
  } result_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_A_RD,
    CMD_A_EV,
    CMD_A_DEC,
    CMD_F_RD,
    CMD_F_EV,
    CMD_F_DEC,
    CMD_D_RD,
    CMD_D_WR,
    CMD_D_END,
    CMD_U_RD,
    CMD_U_WR,
    CMD_U_END,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic is_free;
    logic zero_size;
    logic empty;
    logic a_stop;
    logic f_stop;
    logic alloc_drop;
    logic f_both;
    logic f_ins;
    logic drop_end;
    logic ins_end;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/free_extent_allocator_with_coalescing.sv
// Free extent allocator with coalescing: each input word allocates or frees
// an extent and yields one result word. The free table lives in a 64-entry
// memory with a registered read, so every table entry visited is first read
// and then evaluated or written: a scan reads and evaluates each entry it
// examines (up to 64), and an exact-fit removal, a double merge or an insert
// shifts the entries above the position, one read and one write per entry.
// The next word is taken as soon as the result sits in the output register.
// Depends on feac_pkg, feac_ctrl and feac_datapath.
module free_extent_allocator_with_coalescing import feac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  item_t      in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    out_item_o
);

  cmd_e       cmd;
  dp_status_t st;

  feac_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  feac_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .st_o       (st)
  );

  // Busy after taking a word.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a word back to back");

  // Never overwrite a result that is still waiting.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_EMIT) |-> st.out_free)
    else $error("result register overwritten");

  // A new result appears only after an emit.
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd == CMD_EMIT))
    else $error("result valid without emit");

endmodule

// File: src/feac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module feac_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/feac_datapath.sv
// Datapath: extent table, scan registers, cursor, count and result register.
// Depends on feac_pkg and feac_ram.
module feac_datapath import feac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  input  item_t      in_item_i,
  input  cmd_e       cmd_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output result_t    out_item_o,
  output dp_status_t st_o
);

  logic [1:0]      policy_q;
  item_t           item_q;
  logic [CntW-1:0] count_q, i_q, n_q, p_q;
  logic [IdxW-1:0] cursor_q, drop_q, pick_q;
  logic            found_q, prev_v_q, nxt_v_q, out_v_q;
  entry_t          pick_e_q, prev_q, nxt_q;
  result_t         res_q, out_q;

  logic            re, we;
  logic [IdxW-1:0] raddr, waddr;
  entry_t          wdata, rdata;

  logic [CntW-1:0] i_inc, i_dec, i_wrap, cnt_dec;
  logic            fits, greater, better, mp, mn, full;
  logic [32:0]     prev_end, item_end, sum_prev, sum_nxt;
  logic [33:0]     sum_both;
  logic [31:0]     len_prev, len_nxt, len_both;
  logic [IdxW-1:0] cur_drop, cur_ins;

  feac_ram #(.Width($bits(entry_t)), .Depth(TableDepth)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    i_inc    = i_q + CntW'(1);
    i_dec    = i_q - CntW'(1);
    cnt_dec  = count_q - CntW'(1);
    i_wrap   = (i_inc == count_q) ? '0 : i_inc;
    fits     = rdata.len >= item_q.block_size;
    greater  = rdata.start > item_q.block_address;
    better   = (policy_q == POL_BEST) ? (!found_q || rdata.len < pick_e_q.len) : !found_q;
    prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
    item_end = {1'b0, item_q.block_address} + {1'b0, item_q.block_size};
    mp       = prev_v_q && (prev_end == {1'b0, item_q.block_address});
    mn       = nxt_v_q && (item_end == {1'b0, nxt_q.start});
    full     = count_q >= CntW'(TableDepth);
    sum_prev = {1'b0, prev_q.len} + {1'b0, item_q.block_size};
    sum_nxt  = {1'b0, nxt_q.len} + {1'b0, item_q.block_size};
    sum_both = {1'b0, sum_prev} + {2'b00, nxt_q.len};
    len_prev = sum_prev[32] ? '1 : sum_prev[31:0];
    len_nxt  = sum_nxt[32] ? '1 : sum_nxt[31:0];
    len_both = (sum_both[33:32] != 2'b00) ? '1 : sum_both[31:0];

    // Cursor after dropping entry drop_q; fall back to the start past the end.
    cur_drop = (drop_q < cursor_q) ? cursor_q - IdxW'(1) : cursor_q;
    if ({1'b0, cur_drop} >= cnt_dec) begin
      cur_drop = '0;
    end
    cur_ins = ((count_q != '0) && (p_q <= {1'b0, cursor_q})) ? cursor_q + IdxW'(1)
                                                            : cursor_q;
  end

  always_comb begin
    re    = 1'b0;
    raddr = i_q[IdxW-1:0];
    we    = 1'b0;
    waddr = i_q[IdxW-1:0];
    wdata = rdata;
    case (cmd_i)
      CMD_A_RD, CMD_F_RD: begin
        re = 1'b1;
      end
      CMD_D_RD: begin
        re    = 1'b1;
        raddr = i_inc[IdxW-1:0];
      end
      CMD_U_RD: begin
        re    = 1'b1;
        raddr = i_dec[IdxW-1:0];
      end
      CMD_D_WR, CMD_U_WR: begin
        we = 1'b1;
      end
      CMD_A_DEC: begin
        we    = found_q && (pick_e_q.len != item_q.block_size);
        waddr = pick_q;
        wdata = '{start: pick_e_q.start + item_q.block_size,
                  len:   pick_e_q.len - item_q.block_size};
      end
      CMD_F_DEC: begin
        we = mp || mn;
        if (mp) begin
          waddr = i_dec[IdxW-1:0];
          wdata = '{start: prev_q.start, len: mn ? len_both : len_prev};
        end else begin
          wdata = '{start: item_q.block_address, len: len_nxt};
        end
      end
      CMD_U_END: begin
        we    = 1'b1;
        waddr = p_q[IdxW-1:0];
        wdata = '{start: item_q.block_address, len: item_q.block_size};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      count_q  <= '0;
      cursor_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        policy_q <= cfg_data_i;
      end
      case (cmd_i)
        CMD_A_DEC: begin
          if (found_q && policy_q == POL_NEXT) begin
            cursor_q <= pick_q;
          end
        end
        CMD_F_DEC: begin
          if (mp && mn && {1'b0, cursor_q} == i_q) begin
            cursor_q <= i_dec[IdxW-1:0];
          end
        end
        CMD_D_END: begin
          count_q  <= cnt_dec;
          cursor_q <= cur_drop;
        end
        CMD_U_END: begin
          count_q  <= count_q + CntW'(1);
          cursor_q <= cur_ins;
        end
        default: ;
      endcase
      if (cmd_i == CMD_EMIT) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        item_q   <= in_item_i;
        n_q      <= '0;
        found_q  <= 1'b0;
        prev_v_q <= 1'b0;
        nxt_v_q  <= 1'b0;
        i_q      <= '0;
        if (in_item_i.kind == KIND_ALLOC && policy_q == POL_NEXT &&
            {1'b0, cursor_q} < count_q) begin
          i_q <= {1'b0, cursor_q};
        end
        res_q <= '{status: (in_item_i.kind == KIND_FREE) ? ST_DONE : ST_NOFIT,
                   granted_address: '0, granted_size: '0};
      end
      CMD_A_EV: begin
        if (fits && better) begin
          found_q  <= 1'b1;
          pick_q   <= i_q[IdxW-1:0];
          pick_e_q <= rdata;
        end
        i_q <= i_wrap;
        n_q <= n_q + CntW'(1);
      end
      CMD_A_DEC: begin
        if (found_q) begin
          res_q <= '{status: ST_DONE, granted_address: pick_e_q.start,
                     granted_size: item_q.block_size};
        end
        i_q    <= {1'b0, pick_q};
        drop_q <= pick_q;
      end
      CMD_F_EV: begin
        if (greater) begin
          nxt_q   <= rdata;
          nxt_v_q <= 1'b1;
        end else begin
          prev_q   <= rdata;
          prev_v_q <= 1'b1;
          i_q      <= i_inc;
        end
      end
      CMD_F_DEC: begin
        p_q    <= i_q;
        drop_q <= i_q[IdxW-1:0];
        if (!mp && !mn) begin
          if (full) begin
            res_q.status <= ST_FULL;
          end else begin
            i_q <= count_q;
          end
        end
      end
      CMD_D_WR: i_q <= i_inc;
      CMD_U_WR: i_q <= i_dec;
      CMD_EMIT: out_q <= res_q;
      default: ;
    endcase
  end

  always_comb begin
    st_o.is_free    = item_q.kind == KIND_FREE;
    st_o.zero_size  = item_q.block_size == '0;
    st_o.empty      = count_q == '0;
    st_o.a_stop     = (n_q + CntW'(1) == count_q) || (policy_q != POL_BEST && fits);
    st_o.f_stop     = greater || (i_inc == count_q);
    st_o.alloc_drop = found_q && (pick_e_q.len == item_q.block_size);
    st_o.f_both     = mp && mn;
    st_o.f_ins      = !mp && !mn && !full;
    st_o.drop_end   = i_inc >= count_q;
    st_o.ins_end    = i_q == p_q;
    st_o.out_free   = !out_v_q || !out_stall_i;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// File: src/feac_ctrl.sv
// Controller state machine: sequences scans and table shifts.
// Depends on feac_pkg.
module feac_ctrl import feac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t st_i,
  output cmd_e       cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_A_DEC = 4'd4;
  localparam logic [3:0] S_F_RD  = 4'd5;
  localparam logic [3:0] S_F_EV  = 4'd6;
  localparam logic [3:0] S_F_DEC = 4'd7;
  localparam logic [3:0] S_D_LP  = 4'd8;
  localparam logic [3:0] S_D_WR  = 4'd9;
  localparam logic [3:0] S_U_LP  = 4'd10;
  localparam logic [3:0] S_U_WR  = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_START;
        end
      end
      S_START: begin
        if (st_i.zero_size) begin
          state_d = S_EMIT;
        end else if (st_i.is_free) begin
          state_d = st_i.empty ? S_F_DEC : S_F_RD;
        end else begin
          state_d = st_i.empty ? S_EMIT : S_A_RD;
        end
      end
      S_A_RD: begin
        cmd_o   = CMD_A_RD;
        state_d = S_A_EV;
      end
      S_A_EV: begin
        cmd_o   = CMD_A_EV;
        state_d = st_i.a_stop ? S_A_DEC : S_A_RD;
      end
      S_A_DEC: begin
        cmd_o   = CMD_A_DEC;
        state_d = st_i.alloc_drop ? S_D_LP : S_EMIT;
      end
      S_F_RD: begin
        cmd_o   = CMD_F_RD;
        state_d = S_F_EV;
      end
      S_F_EV: begin
        cmd_o   = CMD_F_EV;
        state_d = st_i.f_stop ? S_F_DEC : S_F_RD;
      end
      S_F_DEC: begin
        cmd_o = CMD_F_DEC;
        if (st_i.f_both) begin
          state_d = S_D_LP;
        end else if (st_i.f_ins) begin
          state_d = S_U_LP;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_D_LP: begin
        if (st_i.drop_end) begin
          cmd_o   = CMD_D_END;
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_D_RD;
          state_d = S_D_WR;
        end
      end
      S_D_WR: begin
        cmd_o   = CMD_D_WR;
        state_d = S_D_LP;
      end
      S_U_LP: begin
        if (st_i.ins_end) begin
          cmd_o   = CMD_U_END;
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_U_RD;
          state_d = S_U_WR;
        end
      end
      S_U_WR: begin
        cmd_o   = CMD_U_WR;
        state_d = S_U_LP;
      end
      S_EMIT: begin
        // Hold the result until the output register frees up.
        if (st_i.out_free) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

// File: sim/tb_free_extent_allocator_with_coalescing.sv
// Self-checking bench for the free extent allocator: a directed table, then random
// alloc/free traffic under every fit policy, checked against a behavioral copy of the table.
// Depends on feac_pkg and free_extent_allocator_with_coalescing.
`timescale 1ns / 1ps
module tb_free_extent_allocator_with_coalescing;
  import feac_pkg::*;

  // Unused policy code; the block treats it as first fit.
  localparam logic [1:0] POL_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_data_i = POL_FIRST;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  result_t out_item_o;

  free_extent_allocator_with_coalescing dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the free table.
  logic [31:0] free_start [TableDepth];
  logic [31:0] free_len [TableDepth];
  int free_cnt = 0;
  int cursor = 0;
  logic [1:0] policy = POL_FIRST;

  result_t grant_q[$];
  logic [63:0] held_q[$];  // {address, size} of granted extents not yet returned
  int errors = 0;
  int idle_pct = 16;
  int stall_pct = 16;

  logic [1:0] phase_pol [5] = '{POL_BEST, POL_NEXT, POL_SPARE, POL_NEXT, POL_FIRST};

  function automatic void remove_extent(int i);
    for (int k = i; k < free_cnt - 1; k++) begin
      free_start[k] = free_start[k + 1];
      free_len[k] = free_len[k + 1];
    end
    free_cnt--;
    if (i < cursor) cursor--;
    if (cursor >= free_cnt) cursor = 0;
  endfunction

  function automatic logic [31:0] clip(logic [33:0] v);
    return (v > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic result_t allocate(logic [31:0] size);
    result_t r;
    int pick;
    int c;
    r = '{status: ST_NOFIT, granted_address: '0, granted_size: '0};
    pick = -1;
    if (size == 0) return r;
    if (policy == POL_BEST) begin
      for (int i = 0; i < free_cnt; i++)
        if (free_len[i] >= size && (pick < 0 || free_len[i] < free_len[pick])) pick = i;
    end else if (policy == POL_NEXT) begin
      c = (cursor < free_cnt) ? cursor : 0;
      for (int i = c; i < free_cnt && pick < 0; i++) if (free_len[i] >= size) pick = i;
      for (int i = 0; i < c && pick < 0; i++) if (free_len[i] >= size) pick = i;
    end else begin
      for (int i = 0; i < free_cnt && pick < 0; i++) if (free_len[i] >= size) pick = i;
    end
    if (pick < 0) return r;
    r = '{status: ST_DONE, granted_address: free_start[pick], granted_size: size};
    if (policy == POL_NEXT) cursor = pick;
    if (free_len[pick] == size) begin
      remove_extent(pick);
    end else begin
      free_start[pick] = free_start[pick] + size;
      free_len[pick] = free_len[pick] - size;
    end
    return r;
  endfunction

  function automatic result_t release_extent(logic [31:0] addr, logic [31:0] size);
    result_t r;
    int p;
    logic mp, mn;
    r = '{status: ST_DONE, granted_address: '0, granted_size: '0};
    p = 0;
    if (size == 0) return r;
    while (p < free_cnt && free_start[p] <= addr) p++;
    mp = p > 0 && ({1'b0, free_start[p - 1]} + free_len[p - 1]) == {1'b0, addr};
    mn = p < free_cnt && ({1'b0, addr} + size) == {1'b0, free_start[p]};
    if (mp && mn) begin
      free_len[p - 1] = clip({2'b0, free_len[p - 1]} + size + free_len[p]);
      if (cursor == p) cursor = p - 1;
      remove_extent(p);
    end else if (mp) begin
      free_len[p - 1] = clip({2'b0, free_len[p - 1]} + size);
    end else if (mn) begin
      free_start[p] = addr;
      free_len[p] = clip({2'b0, free_len[p]} + size);
    end else if (free_cnt >= TableDepth) begin
      r.status = ST_FULL;
    end else begin
      for (int k = free_cnt; k > p; k--) begin
        free_start[k] = free_start[k - 1];
        free_len[k] = free_len[k - 1];
      end
      free_start[p] = addr;
      free_len[p] = size;
      if (free_cnt > 0 && p <= cursor) cursor++;
      free_cnt++;
    end
    return r;
  endfunction

  function automatic result_t apply_word(item_t it);
    result_t r;
    if (it.kind == KIND_ALLOC) begin
      r = allocate(it.block_size);
      if (r.status == ST_DONE) held_q.push_back({r.granted_address, r.granted_size});
    end else begin
      r = release_extent(it.block_address, it.block_size);
    end
    return r;
  endfunction

  // Drive one word and wait for it to be taken; the result is predicted at acceptance.
  task automatic send_word(item_t it, logic fixed, result_t want);
    result_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_word(it);
    grant_q.push_back(fixed ? want : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    policy = p;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result word %h", out_item_o);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
          errors++;
        end
        if (out_item_o.granted_address !== want.granted_address) begin
          $error("granted_address: expected %h, got %h", want.granted_address,
                 out_item_o.granted_address);
          errors++;
        end
        if (out_item_o.granted_size !== want.granted_size) begin
          $error("granted_size: expected %h, got %h", want.granted_size,
                 out_item_o.granted_size);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  typedef struct {
    logic kind;
    logic [31:0] size;
    logic [31:0] addr;
    logic fixed;
    result_t want;
  } row_t;

  localparam result_t NOFIT = '{ST_NOFIT, 32'h0, 32'h0};
  localparam result_t OK    = '{ST_DONE, 32'h0, 32'h0};

  row_t rows [] = '{
    '{KIND_ALLOC, 32'h1, 32'h0, 1'b1, NOFIT},                 // empty table
    '{KIND_ALLOC, 32'h0, 32'h0, 1'b1, NOFIT},                 // zero-size allocate
    '{KIND_FREE, 32'h0, 32'h5, 1'b1, OK},                     // zero-size free
    '{KIND_FREE, 32'h100, 32'h1000, 1'b1, OK},
    '{KIND_FREE, 32'h100, 32'h1200, 1'b1, OK},
    '{KIND_FREE, 32'h100, 32'h1100, 1'b1, OK},                // merges both sides
    '{KIND_ALLOC, 32'h300, 32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h1000, 32'h300}},
    '{KIND_FREE, 32'h100, 32'hFFFF_FF00, 1'b1, OK},
    '{KIND_FREE, 32'h100, 32'h0, 1'b1, OK},                   // no merge across the top
    '{KIND_ALLOC, 32'h100, 32'h0, 1'b1, '{ST_DONE, 32'h0, 32'h100}},
    '{KIND_FREE, 32'hFFFF_FF00, 32'h0, 1'b1, OK},             // merged length saturates
    '{KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1, '{ST_DONE, 32'h0, 32'hFFFF_FFFF}},
    '{KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1, NOFIT},
    '{KIND_FREE, 32'h8000_0000, 32'h8000_0000, 1'b1, OK},
    '{KIND_FREE, 32'h10, 32'h8000_0000, 1'b0, OK},            // equal start goes after
    '{KIND_FREE, 32'h40, 32'hFFFF_FFF0, 1'b0, OK},
    '{KIND_ALLOC, 32'h10, 32'h0, 1'b0, OK},
    '{KIND_ALLOC, 32'h7FFF_FFF0, 32'h0, 1'b0, OK},
    '{KIND_ALLOC, 32'h38, 32'h0, 1'b0, OK},                   // split start wraps
    '{KIND_FREE, 32'h20, 32'h2000, 1'b0, OK},
    '{KIND_ALLOC, 32'h8, 32'h0, 1'b0, OK}
  };

  function automatic item_t random_word();
    item_t it;
    logic [63:0] h;
    int sel;
    int k;
    sel = $urandom_range(99);
    it.kind = KIND_ALLOC;
    it.block_address = $urandom;
    if (sel < 40) begin
      it.block_size = ($urandom_range(3) == 0) ? $urandom_range(1, 4096)
                                               : $urandom_range(1, 64) * 16;
    end else if (sel < 80 && held_q.size() != 0) begin
      k = $urandom_range(held_q.size() - 1);
      h = held_q[k];
      held_q.delete(k);
      it.kind = KIND_FREE;
      it.block_address = h[63:32];
      it.block_size = h[31:0];
    end else if (sel < 95) begin
      it.kind = KIND_FREE;
      it.block_address = 32'h4000_0000 + $urandom_range(0, 4095) * 256;
      it.block_size = $urandom_range(1, 16) * 16;
    end else begin
      it.kind = 1'($urandom_range(1));
      it.block_size = ($urandom_range(7) == 0) ? 32'h0 : $urandom;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_policy(POL_FIRST);
    foreach (rows[i]) begin
      it = '{rows[i].kind, rows[i].size, rows[i].addr};
      send_word(it, rows[i].fixed, rows[i].want);
    end
    for (int ph = 0; ph < 5; ph++) begin
      set_policy(phase_pol[ph]);
      // quiet stretch on both sides for one phase
      idle_pct = (ph == 2) ? 0 : 16;
      stall_pct = (ph == 2) ? 0 : 16;
      if (ph == 3) begin
        // spaced frees that fill the table, then overflow it
        for (int k = 0; k < 72; k++) begin
          it = '{KIND_FREE, 32'h10, 32'hA000_0000 + k * 32'h100};
          send_word(it, 1'b0, OK);
        end
      end
      for (int k = 0; k < 310; k++) send_word(random_word(), 1'b0, OK);
    end
    drain();
    if (errors == 0) begin
      $display("free_extent_allocator_with_coalescing: match");
    end else begin
      $display("free_extent_allocator_with_coalescing: mismatch");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("free_extent_allocator_with_coalescing: mismatch");
    $finish;
  end

endmodule
